### src/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types, sizes and helper functions for the code bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

  // table geometry
  localparam int SYMBOL_COUNT = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int IDX_W        = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  // field widths
  localparam int SYM_W   = 8;
  localparam int CODE_W  = 32;
  localparam int LEN_W   = 6;
  localparam int WORD_W  = 32;
  localparam int CNT_W   = 5;
  localparam int ACT_W   = 2;

  // stream word layout on the input side: symbol, code_bits, code_length
  localparam int IN_DATA_W = 48;

  // item kinds carried on the input tuser
  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_FLUSH  = 2'd2
  } action_t;

  // item after the table read stage
  typedef struct packed {
    logic              valid;
    logic [ACT_W-1:0]  action;
    logic              sym_ok;
    logic [CODE_W-1:0] value;
    logic [LEN_W-1:0]  len;
  } item_t;

  // limit a loaded length to the longest code
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    return (len > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : len;
  endfunction

  // ones in the low len bits, len up to CODE_W
  function automatic logic [CODE_W-1:0] code_mask(input logic [LEN_W-1:0] len);
    logic [CODE_W:0] m;
    m = ({{CODE_W{1'b0}}, 1'b1} << len) - 1'b1;
    return m[CODE_W-1:0];
  endfunction

endpackage

`default_nettype wire

### src/huffman_code_bit_packer.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Table-driven code packer: loads code entries, packs codes into 32-bit
// words msb first, and on request flushes pending bits as a zero-padded final word.
// ----------------------------------------------------------------------------
// The block takes one word per cycle while the output register is empty or
// out_tready is high, with no bubbles between items: a load, encode or flush
// can follow in every such cycle. Each item passes two register stages, the
// code table read (value and length memories, read registered) and the
// accumulator merge into the output register. A load is visible to an encode
// of the same symbol in the very next cycle. Code lengths read as zero after
// reset until loaded, and such symbols add no bits; code values of entries
// never loaded are not defined. in_tuser carries the item kind, out_tlast
// marks a flush word. The output register lets a new item enter an empty
// read stage while a finished word waits for out_tready.
`default_nettype none

module huffman_code_bit_packer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [7:0] symbol, [39:8] code_bits, [45:40] code_length, [47:46] zero
  input  logic [hcbp_pkg::IN_DATA_W-1:0] in_tdata,
  // [1:0] action
  input  logic [hcbp_pkg::ACT_W-1:0]     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [31:0] packed_word
  output logic [hcbp_pkg::WORD_W-1:0]    out_tdata,
  output logic                           out_tlast
);
  import hcbp_pkg::*;

  logic       accept;
  logic       advance;
  item_t      item;

  logic [SYM_W-1:0]  symbol;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_length;

  // input word unpacking
  assign symbol      = in_tdata[SYM_W-1:0];
  assign code_bits   = in_tdata[SYM_W+CODE_W-1:SYM_W];
  assign code_length = in_tdata[SYM_W+CODE_W+LEN_W-1:SYM_W+CODE_W];

  // pipeline flow: both stages move when the output register is free
  assign advance   = !out_tvalid || out_tready;
  assign in_tready = !item.valid || advance;
  assign accept    = in_tvalid && in_tready;

  hcbp_code_table u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .advance     (advance),
    .action      (in_tuser),
    .symbol      (symbol),
    .code_bits   (code_bits),
    .code_length (code_length),
    .item        (item)
  );

  hcbp_packer u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .item      (item),
    .out_valid (out_tvalid),
    .out_word  (out_tdata),
    .out_final (out_tlast)
  );

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  // a new word only comes from an item held in the read stage
  a_word_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(item.valid))
    else $error("result word without an item in the read stage");

  // a table load never produces a word
  a_load_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_tuser == ACT_LOAD)) |=> ##1 !$rose(out_tvalid))
    else $error("table load produced a result word");

  // an item arriving while the read stage is held must not be taken
  a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (item.valid && !advance) |-> !accept)
    else $error("word accepted while the read stage is held");

endmodule

`default_nettype wire

### src/hcbp_code_table.sv
// ----------------------------------------------------------------------------
// hcbp_code_table
// Code value and length memories with per-entry valid bits, plus the
// registered read stage that feeds the packer.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_code_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic                        advance,
  input  logic [hcbp_pkg::ACT_W-1:0]  action,
  input  logic [hcbp_pkg::SYM_W-1:0]  symbol,
  input  logic [hcbp_pkg::CODE_W-1:0] code_bits,
  input  logic [hcbp_pkg::LEN_W-1:0]  code_length,
  output hcbp_pkg::item_t             item
);
  import hcbp_pkg::*;

  logic [CODE_W-1:0]       value_mem [SYMBOL_COUNT];
  logic [LEN_W-1:0]        len_mem   [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] len_vld_r;

  logic [IDX_W-1:0]  idx;
  logic              sym_ok;
  logic [LEN_W-1:0]  len_wr;
  logic              wr_en;

  logic              valid_r;
  logic [ACT_W-1:0]  action_r;
  logic              sym_ok_r;
  logic              hit_r;
  logic [CODE_W-1:0] value_q_r;
  logic [LEN_W-1:0]  len_q_r;

  // address decode and load write enable
  assign idx    = symbol[IDX_W-1:0];
  assign sym_ok = (int'(symbol) < SYMBOL_COUNT);
  assign len_wr = clamp_len(code_length);
  assign wr_en  = accept && (action == ACT_LOAD) && sym_ok;

  // memories: write on load, registered read on every accepted word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      value_mem[idx] <= code_bits & code_mask(len_wr);
      len_mem[idx]   <= len_wr;
    end
    if (accept) begin
      value_q_r <= value_mem[idx];
      len_q_r   <= len_mem[idx];
    end
  end

  // length entries read as zero until loaded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_vld_r <= '0;
    end else if (wr_en) begin
      len_vld_r[idx] <= 1'b1;
    end
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      action_r <= action;
      sym_ok_r <= sym_ok;
      hit_r    <= len_vld_r[idx];
    end
  end

  assign item.valid  = valid_r;
  assign item.action = action_r;
  assign item.sym_ok = sym_ok_r;
  assign item.value  = value_q_r;
  assign item.len    = hit_r ? len_q_r : '0;

endmodule

`default_nettype wire

### src/hcbp_packer.sv
// ----------------------------------------------------------------------------
// hcbp_packer
// Bit accumulator and output register: merges codes msb first, emits full
// words and left-aligned flush words.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_packer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  hcbp_pkg::item_t             item,
  output logic                        out_valid,
  output logic [hcbp_pkg::WORD_W-1:0] out_word,
  output logic                        out_final
);
  import hcbp_pkg::*;

  logic [WORD_W-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]    pend_r, pend_nxt;
  logic                out_valid_r;
  logic [WORD_W-1:0]   out_word_r;
  logic                out_final_r;

  logic                res_vld;
  logic [WORD_W-1:0]   res_word;
  logic                res_final;

  logic [2*WORD_W-1:0] merged;
  logic [2*WORD_W-1:0] shifted;
  logic [LEN_W-1:0]    total;
  logic [LEN_W-1:0]    excess;
  logic [WORD_W-1:0]   keep_mask;

  // merge the code under the pending bits
  always_comb begin
    merged    = ({{WORD_W{1'b0}}, acc_r} << item.len) | {{WORD_W{1'b0}}, item.value};
    total     = LEN_W'(pend_r) + item.len;
    excess    = total - LEN_W'(WORD_W);
    shifted   = merged >> excess;
    keep_mask = ({{(WORD_W-1){1'b0}}, 1'b1} << excess[CNT_W-1:0]) - 1'b1;
  end

  // next state and result
  always_comb begin
    acc_nxt   = acc_r;
    pend_nxt  = pend_r;
    res_vld   = 1'b0;
    res_word  = shifted[WORD_W-1:0];
    res_final = 1'b0;
    if (item.valid) begin
      case (item.action)
        ACT_ENCODE: begin
          if (item.sym_ok && (item.len != '0)) begin
            if (total < LEN_W'(WORD_W)) begin
              acc_nxt  = merged[WORD_W-1:0];
              pend_nxt = total[CNT_W-1:0];
            end else begin
              res_vld  = 1'b1;
              pend_nxt = excess[CNT_W-1:0];
              acc_nxt  = merged[WORD_W-1:0] & keep_mask;
            end
          end
        end
        ACT_FLUSH: begin
          acc_nxt  = '0;
          pend_nxt = '0;
          if (pend_r != '0) begin
            res_vld   = 1'b1;
            res_final = 1'b1;
            res_word  = acc_r << (LEN_W'(WORD_W) - LEN_W'(pend_r));
          end
        end
        default: begin
        end
      endcase
    end
  end

  // accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pend_r <= '0;
    end else if (advance) begin
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_vld) begin
      out_word_r  <= res_word;
      out_final_r <= res_final;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_final = out_final_r;

endmodule

`default_nettype wire
